@@ src/lnwq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnwq_pkg
// Shared types and constants of the character LCD nibble write queue.
// ----------------------------------------------------------------------------
package lnwq_pkg;

	// queue depth in nibble entries; must be even (entries are stored in pairs)
	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 32;
	localparam int FREE_W      = 7;

	// item kinds carried on s_tuser
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_CHAR  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// register index, paddr[4:2]
	localparam logic [2:0] REG_IFACE_READY   = 3'd0;
	localparam logic [2:0] REG_CLOCK_TICKS   = 3'd1;
	localparam logic [2:0] REG_FUNCTION_TICKS = 3'd2;
	localparam logic [2:0] REG_LINE_LENGTH   = 3'd3;
	localparam logic [2:0] REG_SECOND_LINE   = 3'd4;

	localparam logic [15:0] RST_CLOCK_TICKS    = 16'd1;
	localparam logic [15:0] RST_FUNCTION_TICKS = 16'd50;
	localparam logic [6:0]  RST_LINE_LENGTH    = 7'd16;
	localparam logic [6:0]  RST_SECOND_LINE    = 7'd64;

	localparam logic [3:0] CMD_SET_ADDR = 4'h8;

	// bit positions in m_tdata
	localparam int OUT_ACC_BIT = 0;
	localparam int OUT_RS_BIT  = 1;
	localparam int OUT_NIB_LSB = 2;
	localparam int OUT_EN_BIT  = 6;
	localparam int OUT_FREE_LSB = 7;

endpackage : lnwq_pkg
`default_nettype wire

@@ src/lcd_nibble_write_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue
// Nibble write queue and E-strobe timer for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream: one item per handshake. s_tuser = kind (tick, text start,
//    character, no-op); s_tdata = {text_length, value}.
//  - m_* stream: exactly one result item per input item, in order, carrying
//    the accepted flag, the pin levels (RS, D7..D4, E) after the item, and
//    the count of free nibble slots.
//  - APB port sets interface_ready, strobe timing and the line windows.
//    Change registers only while the block is idle.
// Timing: an input register and a result register; one item per cycle
// while m_tready is high. The queue pairs each push of two nibbles into
// one row of a single-port-write memory, so a push costs one write and the
// head row is kept in a register refreshed on every edge (write bypass).
// Stall: while m_tready is low the result register holds; the input
// register still takes one more item, then s_tready drops.
// Reset (arst_n low): queue empty, strobe timer idle, pins low, registers
// at their defaults. No clearing pass; queue rows are never read unwritten.
// QUEUE_DEPTH must be even.
// ----------------------------------------------------------------------------
module lcd_nibble_write_queue #(
	parameter int QUEUE_DEPTH = lnwq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input stream
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// [7:0] value, [15:8] text_length
	input  wire logic [lnwq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  wire logic [lnwq_pkg::IN_TUSER_W-1:0]  s_tuser,
	// result stream
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [0] accepted, [1] pin_rs, [5:2] pin_nibble, [6] pin_enable,
	// [13:7] free_entries, [15:14] zero
	output      logic [lnwq_pkg::OUT_TDATA_W-1:0] m_tdata,
	// configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lnwq_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [lnwq_pkg::CFG_DATA_W-1:0]  pwdata,
	output      logic [lnwq_pkg::CFG_DATA_W-1:0]  prdata,
	output      logic                             pready
);
	import lnwq_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int PAIR_W = PTR_W - 1;
	localparam int PAIRS  = QUEUE_DEPTH / 2;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// ---------------- configuration registers ----------------
	logic        iface_ready_q;
	logic [15:0] clock_ticks_q;
	logic [15:0] function_ticks_q;
	logic [6:0]  line_length_q;
	logic [6:0]  second_line_q;
	logic        cfg_we;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iface_ready_q    <= 1'b0;
			clock_ticks_q    <= RST_CLOCK_TICKS;
			function_ticks_q <= RST_FUNCTION_TICKS;
			line_length_q    <= RST_LINE_LENGTH;
			second_line_q    <= RST_SECOND_LINE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IFACE_READY:    iface_ready_q    <= pwdata[0];
				REG_CLOCK_TICKS:    clock_ticks_q    <= pwdata[15:0];
				REG_FUNCTION_TICKS: function_ticks_q <= pwdata[15:0];
				REG_LINE_LENGTH:    line_length_q    <= pwdata[6:0];
				REG_SECOND_LINE:    second_line_q    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_IFACE_READY:    prdata = {31'd0, iface_ready_q};
			REG_CLOCK_TICKS:    prdata = {16'd0, clock_ticks_q};
			REG_FUNCTION_TICKS: prdata = {16'd0, function_ticks_q};
			REG_LINE_LENGTH:    prdata = {25'd0, line_length_q};
			REG_SECOND_LINE:    prdata = {25'd0, second_line_q};
			default:            prdata = '0;
		endcase
	end

	// ---------------- stage 1: input register ----------------
	logic        valid_s1;
	mode_t       mode_s1;
	logic [7:0]  value_s1;
	logic [7:0]  len_s1;
	logic        valid_s2;
	logic        adv;
	logic        fire;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= mode_t'(s_tuser[1:0]);
			value_s1 <= s_tdata[7:0];
			len_s1   <= s_tdata[15:8];
		end
	end

	// ---------------- control state ----------------
	logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_n;
	logic [PAIR_W-1:0] wr_pair_q, wr_pair_n;
	logic [CNT_W-1:0]  fill_q, fill_n;
	logic              strobe_q, strobe_n;
	logic              settle_q, settle_n;
	logic [15:0]       elapsed_q, elapsed_n;
	logic [7:0]        chars_q, chars_n;
	logic              rs_q, rs_n;
	logic [3:0]        nib_q, nib_n;
	logic              en_q, en_n;

	// queue: rows of two entries, {second, first}; entry = {rs, nibble}
	logic [9:0]        queue_mem [PAIRS];
	logic [9:0]        head_pair_q;
	logic [4:0]        head_entry;
	logic              push;
	logic [9:0]        push_pair;
	logic [PAIR_W-1:0] rd_pair_next;

	logic              acc;
	logic [15:0]       e_inc;
	logic              settle_done;
	logic [CNT_W-1:0]  free_cnt;
	logic              pos_bad;
	logic              no_room;

	assign head_entry = rd_ptr_q[0] ? head_pair_q[9:5] : head_pair_q[4:0];
	assign e_inc      = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign settle_done = !settle_q || (e_inc >= function_ticks_q);
	assign free_cnt   = CNT_W'(QUEUE_DEPTH) - fill_q;

	// cursor outside both line windows
	assign pos_bad = (value_s1 > {1'b0, line_length_q} && value_s1 < {1'b0, second_line_q})
		|| (value_s1 > ({1'b0, second_line_q} + {1'b0, line_length_q}));
	// room for address command plus two nibbles per character
	assign no_room = ({1'b0, len_s1, 1'b0} + 10'd2) > 10'(free_cnt);

	always_comb begin
		rd_ptr_n  = rd_ptr_q;
		wr_pair_n = wr_pair_q;
		fill_n    = fill_q;
		strobe_n  = strobe_q;
		settle_n  = settle_q;
		elapsed_n = elapsed_q;
		chars_n   = chars_q;
		rs_n      = rs_q;
		nib_n     = nib_q;
		en_n      = en_q;
		push      = 1'b0;
		push_pair = '0;
		acc       = 1'b0;
		if (fire) begin
			case (mode_s1)
				MODE_TICK: begin
					if (strobe_q) begin
						if (e_inc < clock_ticks_q) begin
							elapsed_n = e_inc;
						end else begin
							strobe_n  = 1'b0;
							en_n      = 1'b0;
							settle_n  = 1'b1;
							elapsed_n = '0;
						end
					end else if (!settle_done) begin
						elapsed_n = e_inc;
					end else begin
						if (settle_q) begin
							settle_n  = 1'b0;
							elapsed_n = e_inc;
						end
						// take next entry; empty queue leaves the pins alone
						if (fill_q != '0) begin
							rs_n      = head_entry[4];
							nib_n     = head_entry[3:0];
							en_n      = 1'b1;
							strobe_n  = 1'b1;
							elapsed_n = '0;
							rd_ptr_n  = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
								: rd_ptr_q + 1'b1;
							fill_n    = fill_q - 1'b1;
						end
					end
				end
				MODE_START: begin
					if (!iface_ready_q || pos_bad || no_room) begin
						chars_n = '0;
					end else begin
						acc       = 1'b1;
						push      = 1'b1;
						push_pair = {1'b0, value_s1[3:0],
							1'b0, CMD_SET_ADDR | {1'b0, value_s1[6:4]}};
						chars_n   = len_s1;
					end
				end
				MODE_CHAR: begin
					if (chars_q != '0 && free_cnt >= CNT_W'(2)) begin
						acc       = 1'b1;
						push      = 1'b1;
						push_pair = {1'b1, value_s1[3:0], 1'b1, value_s1[7:4]};
						chars_n   = chars_q - 8'd1;
					end
				end
				default: ;
			endcase
			if (push) begin
				wr_pair_n = (wr_pair_q == PAIR_W'(PAIRS - 1)) ? '0 : wr_pair_q + 1'b1;
				fill_n    = fill_q + CNT_W'(2);
			end
		end
	end

	assign rd_pair_next = rd_ptr_n[PTR_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_pair_q <= '0;
			fill_q    <= '0;
			strobe_q  <= 1'b0;
			settle_q  <= 1'b0;
			elapsed_q <= '0;
			chars_q   <= '0;
			rs_q      <= 1'b0;
			nib_q     <= '0;
			en_q      <= 1'b0;
		end else begin
			rd_ptr_q  <= rd_ptr_n;
			wr_pair_q <= wr_pair_n;
			fill_q    <= fill_n;
			strobe_q  <= strobe_n;
			settle_q  <= settle_n;
			elapsed_q <= elapsed_n;
			chars_q   <= chars_n;
			rs_q      <= rs_n;
			nib_q     <= nib_n;
			en_q      <= en_n;
		end
	end

	// head row always mirrors queue_mem[rd_ptr_q >> 1]; same-edge write bypassed
	always_ff @(posedge clk) begin
		if (push) begin
			queue_mem[wr_pair_q] <= push_pair;
		end
		if (push && wr_pair_q == rd_pair_next) begin
			head_pair_q <= push_pair;
		end else begin
			head_pair_q <= queue_mem[rd_pair_next];
		end
	end

	// ---------------- stage 2: result register ----------------
	logic             acc_s2;
	logic             rs_s2;
	logic [3:0]       nib_s2;
	logic             en_s2;
	logic [FREE_W-1:0] free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			acc_s2  <= acc;
			rs_s2   <= rs_n;
			nib_s2  <= nib_n;
			en_s2   <= en_n;
			free_s2 <= FREE_W'(CNT_W'(QUEUE_DEPTH) - fill_n);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, free_s2, en_s2, nib_s2, rs_s2, acc_s2};

endmodule : lcd_nibble_write_queue
`default_nettype wire

@@ src/lnwq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnwq_checker
// Port-level checks on the result stream of the LCD nibble write queue.
// ----------------------------------------------------------------------------
module lnwq_checker #(
	parameter int QUEUE_DEPTH = lnwq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [lnwq_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import lnwq_pkg::*;

	logic              out_hs;
	logic              acc;
	logic              en;
	logic [FREE_W-1:0] free;
	logic [FREE_W-1:0] last_free_q;
	logic              last_en_q;

	assign out_hs = m_tvalid && m_tready;
	assign acc    = m_tdata[OUT_ACC_BIT];
	assign en     = m_tdata[OUT_EN_BIT];
	assign free   = m_tdata[OUT_FREE_LSB +: FREE_W];

	// free count and E level of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_free_q <= FREE_W'(QUEUE_DEPTH);
			last_en_q   <= 1'b0;
		end else if (out_hs) begin
			last_free_q <= free;
			last_en_q   <= en;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_push_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && acc |-> free == last_free_q - FREE_W'(2))
		else $error("accepted item did not take two slots");

	a_refused_or_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && !acc |-> free == last_free_q || free == last_free_q + FREE_W'(1))
		else $error("free count moved without a push or a pop");

	a_strobe_pops: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && en && !last_en_q |-> free == last_free_q + FREE_W'(1))
		else $error("E raised without taking an entry");

endmodule : lnwq_checker

bind lcd_nibble_write_queue lnwq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_lnwq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ bench/lcd_nibble_write_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue_checker
// Watches both streams and the register port, models the queue and strobe
// timer per item, and compares every result item with its prediction.
// ----------------------------------------------------------------------------
module lcd_nibble_write_queue_checker #(
	parameter int QUEUE_DEPTH = lnwq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic [lnwq_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [lnwq_pkg::IN_TUSER_W-1:0]  s_tuser,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic [lnwq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lnwq_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [lnwq_pkg::CFG_DATA_W-1:0]  pwdata,
	input  wire logic [lnwq_pkg::CFG_DATA_W-1:0]  prdata,
	input  wire logic                             pready,
	output int                                    errors,
	output int                                    outstanding
);
	import lnwq_pkg::*;

	typedef struct packed {
		logic       accepted;
		logic       rs;
		logic [3:0] nibble;
		logic       enable;
		logic [6:0] free_slots;
	} pin_state_t;

	// model of the nibble queue: bit 4 RS, bits 3..0 data lines
	logic [4:0] lcd_fifo [QUEUE_DEPTH];
	int         rd_ptr, wr_ptr, fill;
	bit         strobe_high, settling;
	int         tick_count;
	int         chars_armed;
	logic       rs_q, en_q;
	logic [3:0] nib_q;

	// register copies, tracked from the write traffic
	logic       cfg_ready;
	int         cfg_clock, cfg_func, cfg_len, cfg_second;

	pin_state_t expected_pins [$];
	pin_state_t want;
	logic [31:0] read_want;

	function automatic void check_field(string field, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic void push_nibble(logic [4:0] entry);
		lcd_fifo[wr_ptr] = entry;
		wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
		fill++;
	endfunction

	function automatic void bump_ticks();
		if (tick_count < 16'hFFFF)
			tick_count++;
	endfunction

	// one timer tick: hold E, then settle, then pop the next nibble
	function automatic void strobe_tick();
		if (strobe_high) begin
			bump_ticks();
			if (tick_count < cfg_clock)
				return;
			strobe_high = 1'b0;
			en_q        = 1'b0;
			settling    = 1'b1;
			tick_count  = 0;
			return;
		end
		if (settling) begin
			bump_ticks();
			if (tick_count < cfg_func)
				return;
			settling = 1'b0;
		end
		if (fill == 0)
			return;
		{rs_q, nib_q} = lcd_fifo[rd_ptr];
		en_q        = 1'b1;
		strobe_high = 1'b1;
		tick_count  = 0;
		rd_ptr      = (rd_ptr + 1) % QUEUE_DEPTH;
		fill--;
	endfunction

	function automatic logic start_text(logic [7:0] pos, logic [7:0] len);
		logic ok;
		ok = cfg_ready;
		if ((pos > cfg_len && pos < cfg_second) || pos > cfg_second + cfg_len)
			ok = 1'b0;
		if (int'(len) * 2 + 2 > QUEUE_DEPTH - fill)
			ok = 1'b0;
		if (!ok) begin
			chars_armed = 0;
			return 1'b0;
		end
		// set-address command, bit 7 of the address dropped
		push_nibble({1'b0, CMD_SET_ADDR | {1'b0, pos[6:4]}});
		push_nibble({1'b0, pos[3:0]});
		chars_armed = len;
		return 1'b1;
	endfunction

	function automatic logic queue_char(logic [7:0] code);
		if (chars_armed == 0 || QUEUE_DEPTH - fill < 2)
			return 1'b0;
		push_nibble({1'b1, code[7:4]});
		push_nibble({1'b1, code[3:0]});
		chars_armed--;
		return 1'b1;
	endfunction

	function automatic pin_state_t predict_pins(mode_t md, logic [7:0] val, logic [7:0] len);
		pin_state_t p;
		p.accepted = 1'b0;
		case (md)
			MODE_TICK:  strobe_tick();
			MODE_START: p.accepted = start_text(val, len);
			MODE_CHAR:  p.accepted = queue_char(val);
			default:    ;
		endcase
		p.rs         = rs_q;
		p.nibble     = nib_q;
		p.enable     = en_q;
		p.free_slots = 7'(QUEUE_DEPTH - fill);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr      = 0;
			wr_ptr      = 0;
			fill        = 0;
			strobe_high = 1'b0;
			settling    = 1'b0;
			tick_count  = 0;
			chars_armed = 0;
			rs_q        = 1'b0;
			nib_q       = 4'd0;
			en_q        = 1'b0;
			cfg_ready   = 1'b0;
			cfg_clock   = RST_CLOCK_TICKS;
			cfg_func    = RST_FUNCTION_TICKS;
			cfg_len     = RST_LINE_LENGTH;
			cfg_second  = RST_SECOND_LINE;
			expected_pins.delete();
			outstanding <= 0;
		end else begin
			// register port
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
						REG_IFACE_READY:    cfg_ready  = pwdata[0];
						REG_CLOCK_TICKS:    cfg_clock  = pwdata[15:0];
						REG_FUNCTION_TICKS: cfg_func   = pwdata[15:0];
						REG_LINE_LENGTH:    cfg_len    = pwdata[6:0];
						REG_SECOND_LINE:    cfg_second = pwdata[6:0];
						default:            ;
					endcase
				end else begin
					case (paddr[4:2])
						REG_IFACE_READY:    read_want = 32'(cfg_ready);
						REG_CLOCK_TICKS:    read_want = 32'(cfg_clock);
						REG_FUNCTION_TICKS: read_want = 32'(cfg_func);
						REG_LINE_LENGTH:    read_want = 32'(cfg_len);
						REG_SECOND_LINE:    read_want = 32'(cfg_second);
						default:            read_want = prdata;
					endcase
					check_field("prdata", read_want, prdata);
				end
			end

			// results first: an item accepted at this edge cannot be out yet
			if (m_tvalid && m_tready) begin
				if (expected_pins.size() == 0) begin
					$error("result item with nothing expected, m_tdata=0x%h", m_tdata);
					errors++;
				end else begin
					want = expected_pins.pop_front();
					check_field("accepted", want.accepted, m_tdata[OUT_ACC_BIT]);
					check_field("pin_rs", want.rs, m_tdata[OUT_RS_BIT]);
					check_field("pin_nibble", want.nibble, m_tdata[OUT_NIB_LSB +: 4]);
					check_field("pin_enable", want.enable, m_tdata[OUT_EN_BIT]);
					check_field("free_entries", want.free_slots,
						m_tdata[OUT_FREE_LSB +: FREE_W]);
				end
			end

			if (s_tvalid && s_tready)
				expected_pins.push_back(predict_pins(mode_t'(s_tuser), s_tdata[7:0],
					s_tdata[15:8]));

			outstanding <= expected_pins.size();
		end
	end

endmodule : lcd_nibble_write_queue_checker

@@ bench/lcd_nibble_write_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue_tb
// Stimulus and verdict for the LCD nibble write queue. A side checker
// predicts and compares every result item; this module drives the item
// stream, the result back-pressure and the register port.
// ----------------------------------------------------------------------------
module lcd_nibble_write_queue_tb;
	import lnwq_pkg::*;

	localparam int QDEPTH      = DEFAULT_QUEUE_DEPTH;
	// cycles without any handshake before the run is called hung; the
	// slowest legal stretch is a register update or a short random stall
	// run, so this is generous
	localparam int QUIET_LIMIT = 2000;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [7:0] value, [15:8] text_length
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	// [1:0] mode
	logic [IN_TUSER_W-1:0]  s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] accepted, [1] pin_rs, [5:2] pin_nibble, [6] pin_enable,
	// [13:7] free_entries, [15:14] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr    = '0;
	logic [CFG_DATA_W-1:0]  pwdata   = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	int errors;
	int outstanding;

	// pacing: percent of cycles the sender idles / the receiver stalls
	int idle_pct  = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// line window currently programmed, used to aim cursor addresses
	int cur_ll  = RST_LINE_LENGTH;
	int cur_sls = RST_SECOND_LINE;

	lcd_nibble_write_queue #(.QUEUE_DEPTH(QDEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lcd_nibble_write_queue_checker #(.QUEUE_DEPTH(QDEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure, one decision per cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// hang detection: counts cycles in which neither stream moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[lcd_nibble_write_queue] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one item; valid stays up across back-to-back items
	task automatic send_item(mode_t md, logic [7:0] val, logic [7:0] len);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {len, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// sender holds off until every result item is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// setup cycle, access cycle, then idle with psel low
	task automatic apb_access(bit wr, logic [2:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write then read back; the checker compares prdata
	task automatic set_reg(logic [2:0] idx, int unsigned data);
		apb_access(1'b1, idx, data);
		apb_access(1'b0, idx, '0);
	endtask

	task automatic configure(bit ready, int ck, int fn, int ll, int sls);
		wait_drained();
		set_reg(REG_IFACE_READY, ready);
		set_reg(REG_CLOCK_TICKS, ck);
		set_reg(REG_FUNCTION_TICKS, fn);
		set_reg(REG_LINE_LENGTH, ll);
		set_reg(REG_SECOND_LINE, sls);
		cur_ll  = ll;
		cur_sls = sls;
	endtask

	// cursor address inside one of the two line windows
	function automatic logic [7:0] pick_cursor();
		if ($urandom_range(1))
			return 8'($urandom_range(cur_ll));
		return 8'(cur_sls + $urandom_range(cur_ll));
	endfunction

	// start item, then nchars characters with random ticks in between
	task automatic send_text(logic [7:0] pos, int len, int nchars, int tick_max);
		send_item(MODE_START, pos, 8'(len));
		for (int i = 0; i < nchars; i++) begin
			repeat ($urandom_range(tick_max))
				send_tick();
			send_item(MODE_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(int budget, int tick_max);
		int stop_at;
		int roll;
		int len;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			// rotate pacing mixes so every kind lands on every phase
			case ((items_sent / 97) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			roll = $urandom_range(99);
			if (roll < 70) begin
				// well-formed text, mostly short, now and then a full queue's worth
				len = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(5);
				send_text(pick_cursor(), len, len, tick_max);
				repeat ($urandom_range(3 * tick_max + 4))
					send_tick();
			end else if (roll < 85) begin
				// text that may be broken: any address, from no characters to two more than len
				len = $urandom_range(20);
				send_text($urandom_range(1) ? pick_cursor() : 8'($urandom_range(255)),
					len, $urandom_range(len + 2), tick_max);
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(mode_t'($urandom_range(3)), 8'($urandom_range(255)),
						8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset defaults: interface not ready
		send_item(MODE_START, 8'd0, 8'd0);      // refused, not ready
		send_item(MODE_CHAR, 8'h41, 8'd0);      // refused, nothing armed
		send_tick();                            // empty queue, lines hold
		send_item(MODE_NOP, 8'hFF, 8'hFF);

		configure(1'b1, 1, 1, 16, 64);
		send_item(MODE_START, 8'd0, 8'd2);
		send_item(MODE_CHAR, 8'h00, 8'd0);
		send_item(MODE_CHAR, 8'hFF, 8'd0);
		send_item(MODE_CHAR, 8'h55, 8'd0);      // count used up
		send_item(MODE_START, 8'd17, 8'd0);     // between the windows
		send_item(MODE_START, 8'd16, 8'd1);     // last column of line one
		send_item(MODE_START, 8'd80, 8'd1);     // last column of line two, replaces count
		send_item(MODE_START, 8'd81, 8'd0);     // past line two, clears count
		send_item(MODE_CHAR, 8'hAA, 8'd0);      // refused after cleared count
		send_item(MODE_START, 8'd64, 8'd31);    // no room for 64 nibbles
		send_item(MODE_START, 8'hFF, 8'hFF);
		repeat (8)
			send_tick();
		send_item(MODE_NOP, 8'h00, 8'h00);
		repeat (2)
			send_tick();

		// --- random phases; each register update waits for an empty pipe ---
		configure(1'b1, 1, 1, 16, 64);
		run_phase(400, 6);
		configure(1'b1, 2, 3, 64, 0);           // widest line in this bench, second line at zero
		run_phase(350, 10);
		configure(1'b1, 0, 0, 1, 127);          // zero timing acts as one tick
		run_phase(350, 6);
		configure(1'b1, 65535, 65535, 64, 127); // longest strobe and settle
		run_phase(150, 4);
		configure(1'b0, 3, 2, 40, 100);         // not ready: starts refused, queue drains
		run_phase(125, 8);
		configure(1'b1, $urandom_range(1, 4), $urandom_range(1, 4),
			$urandom_range(1, 64), $urandom_range(127));
		run_phase(450, 8);

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("[lcd_nibble_write_queue] OK");
		end else begin
			$display("[lcd_nibble_write_queue] ERROR");
		end
		$finish;
	end

endmodule : lcd_nibble_write_queue_tb

@@ sim.f @@
src/lnwq_pkg.sv
src/lcd_nibble_write_queue.sv
src/lnwq_checker.sv
bench/lcd_nibble_write_queue_checker.sv
bench/lcd_nibble_write_queue_tb.sv
